// File: sv/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg: shared constants and types for the coprime range counter
// Widths of the value path and the prime list.
// ----------------------------------------------------------------------------
package crc_pkg;
    localparam int VALUE_BITS = 32;
    localparam int MAX_PRIMES = 9;
    localparam int CNT_BITS   = 4;
    typedef logic [VALUE_BITS-1:0] t_value;

    // divider request / response
    typedef struct packed {
        logic   start;
        t_value num;
        t_value den;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_value quo;
        t_value rem;
    } t_div_rsp;
endpackage

// File: sv/crc_if.sv
// ----------------------------------------------------------------------------
// crc_if: valid/ready channels
// Query, result and modulus write channels.
// ----------------------------------------------------------------------------
interface crc_query_if;
    logic            valid;
    logic            ready;
    crc_pkg::t_value range_low;
    crc_pkg::t_value range_high;
    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface crc_result_if;
    logic            valid;
    logic            ready;
    crc_pkg::t_value coprime_count;
    modport source (output valid, coprime_count, input ready);
    modport sink   (input valid, coprime_count, output ready);
endinterface

interface crc_cfg_if;
    logic            valid;
    logic            ready;
    crc_pkg::t_value modulus;
    modport source (output valid, modulus, input ready);
    modport sink   (input valid, modulus, output ready);
endinterface

// File: sv/coprime_range_counter_top.sv
// ----------------------------------------------------------------------------
// coprime_range_counter_top: count of integers in [lo,hi] coprime to modulus
// Factors the modulus by trial division, then sums inclusion-exclusion
// terms, all through one shared bit-serial divider.
// ----------------------------------------------------------------------------
// channel   dir  beat carries
// i_cfg     in   modulus (one register)
// i_query   in   range_low, range_high
// o_result  out  coprime_count
//
// Every division runs on the shared divider, from the state that issues it
// to the state that takes the quotient.
// Factoring (only on the first query after reset or a modulus write) costs
// one division per trial divisor up to sqrt of what is left of the modulus,
// plus one per factor stripped: up to ~65536 divides for a large prime
// modulus.
// A query then needs, per subset, one divide per member prime for the
// overflow check plus one divide for the term, at hi and at lo-1.
// Reset clears all control state; the modulus resets to 1.
// The query side is not ready while a query is in flight. A finished count
// waits in the output register until taken; the next query may be taken
// meanwhile and, once done, waits for that register to free up.
// Modulus writes are taken only when idle with no count waiting; while a
// write is offered the query side drops ready.
// ----------------------------------------------------------------------------
module coprime_range_counter_top (
    input  logic i_clk,
    input  logic i_rst_n,
    crc_cfg_if.sink      i_cfg,
    crc_query_if.sink    i_query,
    crc_result_if.source o_result
);
    localparam int W  = crc_pkg::VALUE_BITS;
    localparam int NP = crc_pkg::MAX_PRIMES;
    localparam int CB = crc_pkg::CNT_BITS;
    localparam int JB = $clog2(NP);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FTRY  = 4'd1;  // m / i
    localparam logic [3:0] S_FCHK  = 4'd2;  // test m % i, bound m/i >= i
    localparam logic [3:0] S_FDIV  = 4'd3;  // strip factor i
    localparam logic [3:0] S_FEND  = 4'd4;
    localparam logic [3:0] S_SIDE  = 4'd5;  // start one bound
    localparam logic [3:0] S_PSTEP = 4'd6;  // walk subset members
    localparam logic [3:0] S_PCHK  = 4'd7;
    localparam logic [3:0] S_TERM  = 4'd8;
    localparam logic [3:0] S_TADD  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    r_state;
    crc_pkg::t_value r_mod, r_m, r_i, r_n, r_prod, r_tot, r_hi, r_lo;
    crc_pkg::t_value r_list [NP];
    logic [CB-1:0] r_pcnt;
    logic          r_ready_f, r_side, r_odd, r_big;
    logic [NP:0]   r_sub;
    logic [JB-1:0] r_j;
    logic          r_ovalid;
    crc_pkg::t_value r_res;
    logic          w_out_load;

    crc_pkg::t_div_req w_req;
    crc_pkg::t_div_rsp w_rsp;

    crc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign i_cfg.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign i_query.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign o_result.valid = r_ovalid;
    assign o_result.coprime_count = r_res;

    // finished count moves into the output register once it is free
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || o_result.ready);

    logic [2*W-1:0] w_mul;
    assign w_mul = r_prod * r_list[r_j];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mod     <= crc_pkg::t_value'(1);
            r_pcnt    <= '0;
            r_ready_f <= 1'b0;
            r_ovalid  <= 1'b0;
            w_req.start <= 1'b0;
        end else begin
            w_req.start <= 1'b0;
            r_ovalid <= w_out_load || (r_ovalid && !o_result.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg.valid && i_cfg.ready) begin
                        r_mod <= i_cfg.modulus;
                        r_ready_f <= 1'b0;
                    end else if (i_query.valid && i_query.ready) begin
                        r_lo <= i_query.range_low;
                        r_hi <= i_query.range_high;
                        if (i_query.range_low > i_query.range_high) begin
                            r_tot <= '0; r_state <= S_OUT;
                        end else if (r_mod == '0) begin
                            r_tot <= {{(W-1){1'b0}},
                                (i_query.range_low <= crc_pkg::t_value'(1)) &&
                                (i_query.range_high != '0)};
                            r_state <= S_OUT;
                        end else if (!r_ready_f) begin
                            r_pcnt <= '0; r_m <= r_mod; r_i <= crc_pkg::t_value'(2);
                            w_req.start <= 1'b1; w_req.num <= r_mod;
                            w_req.den <= crc_pkg::t_value'(2);
                            r_state <= S_FCHK;
                        end else begin
                            r_tot <= '0; r_side <= 1'b0; r_state <= S_SIDE;
                        end
                    end
                end
                S_FTRY: begin
                    w_req.start <= 1'b1; w_req.num <= r_m; w_req.den <= r_i;
                    r_state <= S_FCHK;
                end
                S_FCHK: if (w_rsp.done) begin
                    if (w_rsp.quo < r_i) begin
                        r_state <= S_FEND;
                    end else if (w_rsp.rem == '0) begin
                        if (r_pcnt < CB'(NP)) begin
                            r_list[r_pcnt[JB-1:0]] <= r_i;
                            r_pcnt <= r_pcnt + 1'b1;
                        end
                        r_m <= w_rsp.quo;
                        w_req.start <= 1'b1; w_req.num <= w_rsp.quo; w_req.den <= r_i;
                        r_state <= S_FDIV;
                    end else begin
                        r_i <= r_i + 1'b1; r_state <= S_FTRY;
                    end
                end
                S_FDIV: if (w_rsp.done) begin
                    if (w_rsp.rem == '0) begin
                        r_m <= w_rsp.quo;
                        w_req.start <= 1'b1; w_req.num <= w_rsp.quo; w_req.den <= r_i;
                    end else begin
                        r_i <= r_i + 1'b1; r_state <= S_FTRY;
                    end
                end
                S_FEND: begin
                    if (r_m != crc_pkg::t_value'(1) && r_pcnt < CB'(NP)) begin
                        r_list[r_pcnt[JB-1:0]] <= r_m;
                        r_pcnt <= r_pcnt + 1'b1;
                    end
                    r_ready_f <= 1'b1;
                    r_tot <= '0; r_side <= 1'b0; r_state <= S_SIDE;
                end
                S_SIDE: begin
                    // side 0: hi adds, side 1: lo-1 subtracts
                    r_n <= r_side ? ((r_lo == '0) ? '0 : r_lo - 1'b1) : r_hi;
                    r_state <= ((r_side ? r_lo : r_hi) <= crc_pkg::t_value'(r_side))
                               ? S_NEXT : S_PSTEP;
                    // bound of zero: mark the sweep as finished
                    r_sub <= ((r_side ? r_lo : r_hi) <= crc_pkg::t_value'(r_side))
                             ? {1'b1, {NP{1'b0}}} : '0;
                    r_prod <= crc_pkg::t_value'(1); r_j <= '0;
                    r_odd <= 1'b0; r_big <= 1'b0;
                end
                S_PSTEP: begin
                    if (r_big || CB'(r_j) >= r_pcnt) begin
                        r_state <= r_big ? S_NEXT : S_TERM;
                    end else if (r_sub[r_j]) begin
                        w_req.start <= 1'b1; w_req.num <= r_n; w_req.den <= r_list[r_j];
                        r_state <= S_PCHK;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_PCHK: if (w_rsp.done) begin
                    r_odd <= ~r_odd;
                    if (r_prod > w_rsp.quo) r_big <= 1'b1;
                    else r_prod <= w_mul[W-1:0];
                    r_j <= r_j + 1'b1;
                    r_state <= S_PSTEP;
                end
                S_TERM: begin
                    w_req.start <= 1'b1; w_req.num <= r_n; w_req.den <= r_prod;
                    r_state <= S_TADD;
                end
                S_TADD: if (w_rsp.done) begin
                    r_tot <= (r_odd ^ r_side) ? r_tot - w_rsp.quo : r_tot + w_rsp.quo;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_prod <= crc_pkg::t_value'(1); r_j <= '0;
                    r_odd <= 1'b0; r_big <= 1'b0;
                    if ((r_sub + 1'b1) >= ((NP+1)'(1) << r_pcnt)) begin
                        if (r_side) begin
                            r_state <= S_OUT;
                        end else begin
                            r_side <= 1'b1; r_state <= S_SIDE;
                        end
                    end else begin
                        r_sub <= r_sub + 1'b1; r_state <= S_PSTEP;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_res <= r_tot; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/crc_div.sv
// ----------------------------------------------------------------------------
// crc_div: restoring divider, one quotient bit per cycle
// Start latches operands; done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
module crc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crc_pkg::t_div_req i_req,
    output crc_pkg::t_div_rsp o_rsp
);
    localparam int W  = crc_pkg::VALUE_BITS;
    localparam int CB = $clog2(W + 1);

    logic [W-1:0]  r_quo, r_den;
    logic [W:0]    r_rem;
    logic [CB-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_shift, w_diff;

    assign w_shift = {r_rem[W-1:0], r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= CB'(W);
            end else if (r_busy) begin
                if (w_diff[W]) begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end else begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[W-1:0];
endmodule

// File: tb/crc_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_tb_pkg: testbench constants
// Length of the long receiver hold-off.
// ----------------------------------------------------------------------------
package crc_tb_pkg;
    localparam int HOLD_CYCLES = 50000;
endpackage

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for coprime_range_counter_top
// Drives modulus writes and range queries with random gaps on both sides.
// A scoreboard predicts each count by inclusion-exclusion over the distinct
// primes of the modulus and checks results in order.
// ----------------------------------------------------------------------------
module tb;
    localparam int STALL_LIMIT = 2000000;

    // predictor and store of expected counts
    class coprime_scoreboard;
        crc_pkg::t_value   modulus;
        longint unsigned   primes[crc_pkg::MAX_PRIMES];
        int unsigned       prime_cnt;
        bit                factored;
        crc_pkg::t_value   expected_counts[$];
        int unsigned       errors;

        function new();
            modulus   = 1;
            prime_cnt = 0;
            factored  = 0;
            errors    = 0;
        endfunction

        function void set_modulus(crc_pkg::t_value v);
            modulus  = v;
            factored = 0;
        endfunction

        function void factor();
            longint unsigned m;
            longint unsigned d;
            m = modulus;
            prime_cnt = 0;
            if (m != 0) begin
                for (d = 2; d <= m / d; d++) begin
                    if (m % d == 0) begin
                        if (prime_cnt < crc_pkg::MAX_PRIMES) begin
                            primes[prime_cnt] = d;
                            prime_cnt++;
                        end
                        while (m % d == 0) m = m / d;
                    end
                end
                if (m != 1 && prime_cnt < crc_pkg::MAX_PRIMES) begin
                    primes[prime_cnt] = m;
                    prime_cnt++;
                end
            end
            factored = 1;
        endfunction

        // count of 1..n with no kept prime as divisor, wrapping sum
        function longint unsigned coprime_upto(longint unsigned n);
            longint unsigned total;
            longint unsigned prod;
            int unsigned     members;
            bit              too_big;
            total = 0;
            if (n == 0) return 0;
            for (int unsigned sub = 0; sub < (32'd1 << prime_cnt); sub++) begin
                prod    = 1;
                members = 0;
                too_big = 0;
                for (int j = 0; j < prime_cnt; j++) begin
                    if (sub[j]) begin
                        members++;
                        if (prod > n / primes[j]) too_big = 1;
                        else prod = prod * primes[j];
                    end
                end
                if (!too_big) begin
                    if (members[0]) total = total - n / prod;
                    else total = total + n / prod;
                end
            end
            return total;
        endfunction

        function void note_query(crc_pkg::t_value lo, crc_pkg::t_value hi);
            longint unsigned res;
            if (!factored) factor();
            if (lo > hi) res = 0;
            else if (modulus == 0) res = (lo <= 1 && hi >= 1) ? 1 : 0;
            else res = coprime_upto(hi) - coprime_upto((lo == 0) ? 0 : lo - 1);
            expected_counts = {expected_counts, crc_pkg::t_value'(res)};
        endfunction

        function void check_count(crc_pkg::t_value actual);
            crc_pkg::t_value want;
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, actual);
                errors++;
            end else begin
                want = expected_counts.pop_front();
                if (want !== actual) begin
                    $display("%0t: coprime_count expected %0d actual %0d",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_counts.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    crc_cfg_if    cfg_ch();
    crc_query_if  query_ch();
    crc_result_if result_ch();

    coprime_range_counter_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch.sink),
        .i_query  (query_ch.sink),
        .o_result (result_ch.source)
    );

    coprime_scoreboard sb;
    bit          calm;                 // no idling on either side while set
    int unsigned hold_req;             // receiver hold-off length, set by sender
    bit          hold_taken   = 1'b0;  // receiver side only
    int unsigned hold_left    = 0;
    int unsigned stall_cycles = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0 && !hold_taken) begin
            hold_left  = hold_req;
            hold_taken = 1'b1;
        end
        if (hold_left != 0) begin
            result_ch.ready = 1'b0;
            hold_left--;
        end else begin
            result_ch.ready = calm || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_count(result_ch.coprime_count);
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (result_ch.valid && result_ch.ready) ||
            (query_ch.valid && query_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("coprime_range_counter_top: mismatch");
                $finish;
            end
        end
    end

    // one query beat; returns in the step of the accepting edge
    task automatic send_query(crc_pkg::t_value lo, crc_pkg::t_value hi);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 35) begin
            query_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        query_ch.valid      = 1'b1;
        query_ch.range_low  = lo;
        query_ch.range_high = hi;
        do @(posedge i_clk); while (!query_ch.ready);
        sb.note_query(lo, hi);
    endtask

    task automatic drain();
        @(negedge i_clk);
        query_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // modulus write, only with the block idle
    task automatic write_modulus(crc_pkg::t_value v);
        drain();
        @(negedge i_clk);
        cfg_ch.valid   = 1'b1;
        cfg_ch.modulus = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_modulus(v);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic bit is_prime(int unsigned p);
        for (int unsigned d = 2; d * d <= p; d++)
            if (p % d == 0) return 0;
        return p >= 2;
    endfunction

    // moduli with cheap factoring: small primes, maybe one prime below 2^20
    function automatic crc_pkg::t_value pick_modulus();
        int unsigned small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        longint unsigned m;
        int unsigned     p;
        m = 1;
        repeat ($urandom_range(3, 1)) begin
            p = small_primes[$urandom_range(10)];
            repeat ($urandom_range(3, 1)) if (m * p < 64'd4096) m = m * p;
        end
        if ($urandom_range(1)) begin
            do p = $urandom_range(32'h000F_FFFF, 32'h0001_0000) | 1;
            while (!is_prime(p));
            m = m * p;
        end
        return crc_pkg::t_value'(m);
    endfunction

    task automatic random_query();
        crc_pkg::t_value a, b, t;
        a = $urandom();
        b = $urandom();
        case ($urandom_range(9))
            0, 1: ;                          // unordered, may be empty
            2, 3: begin                      // short range near a random point
                b = a + $urandom_range(300);
                if (b < a) b = a;
            end
            4: begin                         // small values around zero and one
                a = $urandom_range(3);
                b = $urandom_range(50);
            end
            default: if (a > b) begin
                t = a; a = b; b = t;
            end
        endcase
        send_query(a, b);
    endtask

    initial begin
        sb       = new();
        calm     = 0;
        hold_req = 0;
        i_rst_n  = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.modulus = '0;
        query_ch.valid = 1'b0;
        query_ch.range_low = '0;
        query_ch.range_high = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // modulus at its reset value of one: every x counts
        send_query(0, 0);
        send_query(0, 1);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(5, 3);                      // empty range
        send_query(0, 32'hFFFF_FFFF);          // full range, largest count
        send_query(32'hFFFF_FFFF, 0);

        write_modulus(12);
        send_query(0, 100);
        send_query(7, 7);
        send_query(0, 32'hFFFF_FFFF);

        // modulus zero: only x = 1 counts
        write_modulus(0);
        send_query(0, 0);
        send_query(1, 1);
        send_query(2, 32'hFFFF_FFFF);
        send_query(0, 5);

        // all ones: 3*5*17*257*65537
        write_modulus(32'hFFFF_FFFF);
        send_query(0, 32'hFFFF_FFFF);
        send_query(1, 65537);
        send_query(65537, 65537);

        // nine distinct primes, full subset sweep; small n hits big products
        write_modulus(32'd223092870);
        send_query(0, 32'hFFFF_FFFF);
        send_query(1000, 2000);

        write_modulus(32'h8000_0000);
        send_query(0, 32'hFFFF_FFFF);
        send_query(32'h8000_0000, 32'h8000_0001);

        // random phases, each with a fresh modulus
        for (int ph = 0; ph < 6; ph++) begin
            write_modulus(pick_modulus());
            calm = (ph == 2);
            if (ph == 3) hold_req = crc_tb_pkg::HOLD_CYCLES;
            for (int n = 0; n < 14; n++) begin
                if (ph == 4 && n == 7) drain();    // sender waits for all results
                random_query();
            end
        end
        calm = 0;

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("coprime_range_counter_top: match");
        end else begin
            $display("coprime_range_counter_top: mismatch");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/crc_pkg.sv
sv/crc_if.sv
sv/crc_div.sv
sv/coprime_range_counter_top.sv
tb/crc_tb_if.sv
tb/tb.sv
